[sv/dfvc_pkg.sv]
// ----------------------------------------------------------------------------
// dfvc_pkg
// Shared types and constants of the density feedback valve controller.
// ----------------------------------------------------------------------------
package dfvc_pkg;

	localparam int SHOTS_PER_DISCHARGE = 128;
	localparam int CNT_W               = $clog2(SHOTS_PER_DISCHARGE);

	localparam int NUM_CHAN   = 5;
	localparam int CHAN_W     = 20;
	localparam int LANE_W     = CHAN_W + 3;
	localparam int SUM_W      = LANE_W - 1;
	localparam int DENS_W     = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_VALVE_OFFSET    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALVE_GAIN      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_START_SHOT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD  = 4'd3;

	// scale factors and reciprocals for the constant divisions
	localparam logic [4:0]  PE_MUL     = 5'd23;
	localparam logic [11:0] MEAS_MUL   = 12'd4071;
	localparam logic [19:0] RECIP_125  = 20'd536871;
	localparam logic [17:0] RECIP_5    = 18'd209716;
	localparam logic [14:0] RECIP_5V   = 15'd26215;
	localparam logic [12:0] PE_MAX     = 13'd4095;
	localparam logic [11:0] VALVE_MAX  = 12'd3000;
	localparam logic [20:0] VALVE_SAT  = 21'd1920000;

	typedef struct packed {
		logic [23:0] valve_offset;
		logic [23:0] valve_gain;
		logic [6:0]  lock_start_shot;
		logic [23:0] lock_threshold;
	} dfvc_cfg_t;

	typedef struct packed {
		logic load;
		logic sum_en;
	} dfvc_ctl_t;

	typedef struct packed {
		logic [6:0]  shot_index;
		logic [11:0] pe_dac_code;
		logic [11:0] valve_dac_code;
		logic [15:0] measured_density;
		logic [24:0] density_error;
		logic        locked;
		logic [6:0]  lock_shot;
		logic        last_shot;
	} dfvc_res_t;

endpackage

[sv/dfvc_if.sv]
// ----------------------------------------------------------------------------
// dfvc interfaces
// Shot request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface dfvc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] chan_a;
	logic [19:0] chan_b;
	logic [19:0] chan_c;
	logic [19:0] chan_d;
	logic [19:0] chan_e;
	logic [23:0] target_density;

	modport source (output valid, chan_a, chan_b, chan_c, chan_d, chan_e, target_density,
		input ready);
	modport sink (input valid, chan_a, chan_b, chan_c, chan_d, chan_e, target_density,
		output ready);
endinterface

interface dfvc_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  shot_index;
	logic [11:0] pe_dac_code;
	logic [11:0] valve_dac_code;
	logic [15:0] measured_density;
	logic [24:0] density_error;
	logic        locked;
	logic [6:0]  lock_shot;
	logic        last_shot;

	modport source (output valid, shot_index, pe_dac_code, valve_dac_code, measured_density,
		density_error, locked, lock_shot, last_shot, input ready);
	modport sink (input valid, shot_index, pe_dac_code, valve_dac_code, measured_density,
		density_error, locked, lock_shot, last_shot, output ready);
endinterface

interface dfvc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/density_feedback_valve_controller_top.sv]
// ----------------------------------------------------------------------------
// density_feedback_valve_controller_top
// One result per laser shot. A shot request is taken when the block is idle;
// five channel lanes capture and sign-extend the photoelectron values, a merge
// stage sums and clamps them, and the core sequencer then steps through the
// scaling multiplies, the lock decision and the valve law. After the accept a
// shot passes through eight sequencer steps, and the last of them waits until
// the result register is free. The result register lets the next shot be
// taken while a result waits. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module density_feedback_valve_controller_top
	import dfvc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	dfvc_in_if.sink   samples,
	dfvc_out_if.source results,
	dfvc_cfg_if.sink  cfg
);

	dfvc_cfg_t         cfg_q;
	dfvc_ctl_t         ctl;
	dfvc_res_t         res;
	logic              idle;
	logic              in_fire;
	logic [CHAN_W-1:0] chans [NUM_CHAN];
	logic [LANE_W-1:0] lanes [NUM_CHAN];
	logic [SUM_W-1:0]  sum;

	assign samples.ready = idle;
	assign in_fire       = samples.valid && idle;
	assign cfg.ready     = 1'b1;

	assign chans[0] = samples.chan_a;
	assign chans[1] = samples.chan_b;
	assign chans[2] = samples.chan_c;
	assign chans[3] = samples.chan_d;
	assign chans[4] = samples.chan_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_VALVE_OFFSET:    cfg_q.valve_offset    <= cfg.data;
				REG_VALVE_GAIN:      cfg_q.valve_gain      <= cfg.data;
				REG_LOCK_START_SHOT: cfg_q.lock_start_shot <= cfg.data[6:0];
				REG_LOCK_THRESHOLD:  cfg_q.lock_threshold  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
		dfvc_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.chan   (chans[g]),
			.lane_q (lanes[g])
		);
	end

	dfvc_merge u_merge (
		.clk   (clk),
		.ctl   (ctl),
		.lanes (lanes),
		.sum_q (sum)
	);

	dfvc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.target      (samples.target_density),
		.idle        (idle),
		.ctl         (ctl),
		.sum         (sum),
		.cfg         (cfg_q),
		.out_valid_q (results.valid),
		.out_ready   (results.ready),
		.res_q       (res)
	);

	assign results.shot_index       = res.shot_index;
	assign results.pe_dac_code      = res.pe_dac_code;
	assign results.valve_dac_code   = res.valve_dac_code;
	assign results.measured_density = res.measured_density;
	assign results.density_error    = res.density_error;
	assign results.locked           = res.locked;
	assign results.lock_shot        = res.lock_shot;
	assign results.last_shot        = res.last_shot;

endmodule

[sv/dfvc_lane.sv]
// ----------------------------------------------------------------------------
// dfvc_lane
// One photoelectron channel lane: sign extension and capture per shot.
// ----------------------------------------------------------------------------
module dfvc_lane
	import dfvc_pkg::*;
(
	input  logic              clk,
	input  dfvc_ctl_t         ctl,
	input  logic [CHAN_W-1:0] chan,
	output logic [LANE_W-1:0] lane_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lane_q <= {{(LANE_W-CHAN_W){chan[CHAN_W-1]}}, chan};
		end
	end

endmodule

[sv/dfvc_merge.sv]
// ----------------------------------------------------------------------------
// dfvc_merge
// Adds the lane values and clamps the channel sum at zero.
// ----------------------------------------------------------------------------
module dfvc_merge
	import dfvc_pkg::*;
(
	input  logic              clk,
	input  dfvc_ctl_t         ctl,
	input  logic [LANE_W-1:0] lanes [NUM_CHAN],
	output logic [SUM_W-1:0]  sum_q
);

	logic [LANE_W-1:0] total;

	always_comb begin
		total = '0;
		for (int i = 0; i < NUM_CHAN; i++) begin
			total = total + lanes[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			sum_q <= total[LANE_W-1] ? '0 : total[SUM_W-1:0];
		end
	end

endmodule

[sv/dfvc_core.sv]
// ----------------------------------------------------------------------------
// dfvc_core
// Shot sequencer: scaling, density, lock latch, valve law and result register.
// ----------------------------------------------------------------------------
module dfvc_core
	import dfvc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [23:0]      target,
	output logic             idle,
	output dfvc_ctl_t        ctl,
	input  logic [SUM_W-1:0] sum,
	input  dfvc_cfg_t        cfg,
	output logic             out_valid_q,
	input  logic             out_ready,
	output dfvc_res_t        res_q
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUM, ST_MUL1, ST_MUL2, ST_LOCK, ST_VMUL, ST_VADD, ST_VDIV, ST_DONE
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   cnt_q;
	logic               lock_q;
	logic [6:0]         lock_shot_q;
	logic [23:0]        target_q;
	logic [25:0]        p23_q;
	logic [33:0]        p4071_q;
	logic [38:0]        q125_q;
	logic [34:0]        q5_q;
	logic [11:0]        pe_q;
	logic [15:0]        meas_q;
	logic signed [24:0] err_q;
	logic               valve_en_q;
	logic               res_locked_q;
	logic [6:0]         res_lock_shot_q;
	logic signed [48:0] vprod_q;
	logic signed [49:0] v_q;
	logic [28:0]        vdiv_q;
	logic               vsat_q;
	logic               vpos_q;

	logic [12:0]        pe_full;
	logic [14:0]        meas15;
	logic signed [24:0] err_c;
	logic               lock_hit;
	logic               lock_now;
	logic               last_c;
	logic               out_load;
	logic [11:0]        valve_c;
	logic [23:0]        offset_s;

	assign idle       = (state_q == ST_IDLE);
	assign ctl.load   = in_fire;
	assign ctl.sum_en = (state_q == ST_SUM);

	assign pe_full  = q125_q[38:26];
	assign meas15   = q5_q[34:20];
	assign err_c    = $signed({1'b0, target_q}) - $signed({10'b0, meas15});
	assign lock_hit = !lock_q && (cnt_q >= cfg.lock_start_shot)
		&& (24'(meas15) < cfg.lock_threshold);
	assign lock_now = lock_q || lock_hit;
	assign last_c   = (cnt_q == CNT_W'(SHOTS_PER_DISCHARGE - 1));
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign offset_s = cfg.valve_offset;
	assign valve_c  = (!valve_en_q || !vpos_q) ? 12'd0 :
		vsat_q ? VALVE_MAX : vdiv_q[28:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lock_q      <= 1'b0;
			lock_shot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						target_q <= target;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					p23_q   <= 26'(sum) * 26'(PE_MUL);
					p4071_q <= 34'(sum) * 34'(MEAS_MUL);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					q125_q  <= 39'(p23_q[25:7]) * 39'(RECIP_125);
					q5_q    <= 35'(p4071_q[33:17]) * 35'(RECIP_5);
					state_q <= ST_LOCK;
				end
				ST_LOCK: begin
					pe_q         <= (pe_full > PE_MAX) ? PE_MAX[11:0] : pe_full[11:0];
					meas_q       <= 16'(meas15);
					err_q        <= err_c;
					valve_en_q   <= !err_c[24] && (err_c != '0) && !lock_now;
					res_locked_q <= lock_now;
					if (lock_hit) begin
						lock_q          <= 1'b1;
						lock_shot_q     <= 7'(cnt_q);
						res_lock_shot_q <= 7'(cnt_q);
					end else begin
						res_lock_shot_q <= lock_shot_q;
					end
					state_q <= ST_VMUL;
				end
				ST_VMUL: begin
					vprod_q <= 49'(err_q) * 49'($signed(cfg.valve_gain));
					state_q <= ST_VADD;
				end
				ST_VADD: begin
					v_q     <= $signed({{26{offset_s[23]}}, offset_s}) +
						$signed({vprod_q[48], vprod_q});
					state_q <= ST_VDIV;
				end
				ST_VDIV: begin
					vpos_q  <= !v_q[49] && (v_q != '0);
					vsat_q  <= (v_q[48:21] != '0) || (v_q[20:0] >= VALVE_SAT);
					vdiv_q  <= 29'(v_q[20:7]) * 29'(RECIP_5V);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						res_q.shot_index       <= 7'(cnt_q);
						res_q.pe_dac_code      <= pe_q;
						res_q.valve_dac_code   <= valve_c;
						res_q.measured_density <= meas_q;
						res_q.density_error    <= err_q;
						res_q.locked           <= res_locked_q;
						res_q.lock_shot        <= res_lock_shot_q;
						res_q.last_shot        <= last_c;
						if (last_c) begin
							cnt_q       <= '0;
							lock_q      <= 1'b0;
							lock_shot_q <= '0;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_valve_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.valve_dac_code == '0) ||
		(!res_q.locked && !res_q.density_error[24] && res_q.density_error != '0))
		else $error("valve open while locked or error not positive");

	a_valve_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.valve_dac_code <= VALVE_MAX)
		else $error("valve code above cap");

	a_lock_shot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.locked |-> res_q.lock_shot == '0)
		else $error("lock shot set without lock");

	a_discharge_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_c |=> cnt_q == '0 && !lock_q && lock_shot_q == '0)
		else $error("discharge state not cleared after last shot");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> idle ##1 state_q == ST_SUM)
		else $error("request taken while busy");
`endif

endmodule
